// File: hdl/tvts_pkg.sv
// tvts_pkg: constants, types and the sine table of the two-voice tone sequencer
// used by tvts_ctrl, tvts_datapath, two_voice_tone_sequencer and tvts_checker
package tvts_pkg;

    localparam int TRACKS           = 2;
    localparam int TONES_PER_TRACK  = 6;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int ENTRY_COUNT = TRACKS * TONES_PER_TRACK;
    localparam int TRK_W       = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int ENT_W       = (TONES_PER_TRACK > 1) ? $clog2(TONES_PER_TRACK) : 1;
    localparam int EADDR_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int SINE_AW     = $clog2(SINE_TABLE_DEPTH);
    localparam int ACC_W       = 16 + TRK_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;

    localparam logic [19:0] SLOT_LENGTH_RST = 20'd19200;
    localparam logic [7:0]  SLOT_COUNT_RST  = 8'd9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [5:0][63:0] SINE_DIVS = {64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef struct packed {
        logic [7:0]  begin_slot;
        logic [7:0]  end_slot;
        logic [30:0] phase_step;
        logic [13:0] amplitude;
    } t_entry;

    typedef struct packed {
        logic             wr_entry;
        logic             scan_clr;
        logic             rd_en;
        logic             check;
        logic             acc_clr;
        logic             ph_step;
        logic             rom_rd;
        logic             mul;
        logic             acc;
        logic             out_load;
        logic [TRK_W-1:0] trk;
        logic [ENT_W-1:0] ent;
    } t_cmd;

    typedef struct packed {
        logic slot_start;
    } t_status;

    typedef logic [SINE_TABLE_DEPTH-1:0][15:0] t_sine_rom;

    // first-quadrant fold, taylor series through x^13 in q30, scale to q1.15
    function automatic logic [15:0] sine_of_phase(input logic [31:0] p);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] res;
        logic signed [63:0] sum;
        r = {34'd0, p[29:0]};
        if (p[30]) begin
            r = (64'd1 << 30) - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int i = 0; i < 6; i++) begin
            term = ((term * x2) >> 30) / SINE_DIVS[i];
            if (i[0]) begin
                sum = sum + signed'(term);
            end else begin
                sum = sum - signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        res = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (res > 64'd32767) begin
            res = 64'd32767;
        end
        return p[31] ? (16'd0 - res[15:0]) : res[15:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_of_phase(32'(k) << (32 - SINE_AW));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// File: hdl/tvts_ctrl.sv
// tvts_ctrl: sequencer for table writes, slot-start scan and serial voice steps
// depends on tvts_pkg; drives tvts_datapath by command, holds the result valid
module tvts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_op,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tvts_pkg::t_status i_status,
    output tvts_pkg::t_cmd   o_cmd
);
    import tvts_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CHK = 3'd2;
    localparam logic [2:0] S_PH       = 3'd3;
    localparam logic [2:0] S_ROM      = 3'd4;
    localparam logic [2:0] S_MUL      = 3'd5;
    localparam logic [2:0] S_ACC      = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [TRK_W-1:0] r_trk, n_trk;
    logic [ENT_W-1:0] r_ent, n_ent;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_last_trk;
    logic             w_last_ent;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last_trk  = (r_trk == TRK_W'(TRACKS - 1));
    assign w_last_ent  = (r_ent == ENT_W'(TONES_PER_TRACK - 1));

    always_comb begin
        n_state     = r_state;
        n_trk       = r_trk;
        n_ent       = r_ent;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.trk   = r_trk;
        o_cmd.ent   = r_ent;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_WRITE) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.acc_clr = 1'b1;
                        n_trk         = '0;
                        n_ent         = '0;
                        if (i_status.slot_start) begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_SCAN_RD;
                        end else begin
                            n_state = S_PH;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.check = 1'b1;
                n_state     = S_SCAN_RD;
                if (w_last_ent) begin
                    n_ent = '0;
                    if (w_last_trk) begin
                        n_trk   = '0;
                        n_state = S_PH;
                    end else begin
                        n_trk = r_trk + TRK_W'(1);
                    end
                end else begin
                    n_ent = r_ent + ENT_W'(1);
                end
            end
            S_PH: begin
                o_cmd.ph_step = 1'b1;
                n_state       = S_ROM;
            end
            S_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (w_last_trk) begin
                    n_trk   = '0;
                    n_state = S_FIN;
                end else begin
                    n_trk   = r_trk + TRK_W'(1);
                    n_state = S_PH;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_trk       <= '0;
            r_ent       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_trk       <= n_trk;
            r_ent       <= n_ent;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/tvts_datapath.sv
// tvts_datapath: tone table memory, voice registers, sine rom, multiply and sum
// depends on tvts_pkg; commanded by tvts_ctrl
module tvts_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tvts_pkg::t_cmd                    i_cmd,
    output tvts_pkg::t_status                 o_status,
    input  logic                              i_cfg_valid,
    input  logic [tvts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tvts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_track,
    input  logic [2:0]                        i_entry_index,
    input  logic [7:0]                        i_begin_slot,
    input  logic [7:0]                        i_end_slot,
    input  logic [30:0]                       i_phase_step,
    input  logic [13:0]                       i_amplitude,
    output logic signed [15:0]                o_sample,
    output logic [7:0]                        o_slot_index,
    output logic                              o_song_end
);
    import tvts_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    t_entry r_mem [ENTRY_COUNT];
    t_entry r_entry;

    logic [19:0]              r_len;
    logic [7:0]               r_cnt;
    logic [19:0]              r_sis;
    logic [7:0]               r_slot;
    logic [TRACKS-1:0]        r_found;
    logic [31:0]              r_phase [TRACKS];
    logic [30:0]              r_vstep [TRACKS];
    logic [13:0]              r_vamp  [TRACKS];
    logic signed [15:0]       r_sine;
    logic signed [30:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [15:0]       r_sample;
    logic [7:0]               r_oslot;
    logic                     r_oend;

    logic [EADDR_W-1:0]       w_wr_addr;
    logic [EADDR_W-1:0]       w_rd_addr;
    logic                     w_wr_ok;
    logic                     w_hit;
    logic [30:0]              w_mag;
    logic [15:0]              w_v;
    logic                     w_slot_done;
    logic                     w_wrap;
    logic signed [15:0]       w_sat;

    assign w_wr_addr = EADDR_W'(32'(i_track) * TONES_PER_TRACK + 32'(i_entry_index));
    assign w_rd_addr = EADDR_W'(32'(i_cmd.trk) * TONES_PER_TRACK + 32'(i_cmd.ent));
    assign w_wr_ok   = (32'(i_track) < TRACKS) && (32'(i_entry_index) < TONES_PER_TRACK);
    assign w_hit     = (r_slot >= r_entry.begin_slot) && (r_slot <= r_entry.end_slot);

    assign w_mag = r_prod[30] ? 31'(-r_prod) : 31'(r_prod);
    assign w_v   = 16'((w_mag + 31'd16384) >> 15);

    assign w_slot_done = ({1'b0, r_sis} + 21'd1) >= {1'b0, r_len};
    assign w_wrap      = ({1'b0, r_slot} + 9'd1) >= {1'b0, r_cnt};

    always_comb begin
        if (r_acc > SAT_HI) begin
            w_sat = 16'sd32767;
        end else if (r_acc < SAT_LO) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = 16'(r_acc);
        end
    end

    assign o_status.slot_start = (r_sis == 20'd0);
    assign o_sample            = r_sample;
    assign o_slot_index        = r_oslot;
    assign o_song_end          = r_oend;

    // tone table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && w_wr_ok) begin
            r_mem[w_wr_addr] <= '{begin_slot: i_begin_slot, end_slot: i_end_slot,
                                  phase_step: i_phase_step, amplitude: i_amplitude};
        end
        if (i_cmd.rd_en) begin
            r_entry <= r_mem[w_rd_addr];
        end
    end

    // sine rom, multiply and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_rd) begin
            r_sine <= signed'(SINE_ROM[r_phase[i_cmd.trk][31 -: SINE_AW]]);
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_vamp[i_cmd.trk]}) * r_sine;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            if (r_prod[30]) begin
                r_acc <= r_acc - signed'(ACC_W'(w_v));
            end else begin
                r_acc <= r_acc + signed'(ACC_W'(w_v));
            end
        end
        if (i_cmd.out_load) begin
            r_sample <= w_sat;
            r_oslot  <= r_slot;
            r_oend   <= w_slot_done && w_wrap;
        end
    end

    // configuration, song position and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= SLOT_LENGTH_RST;
            r_cnt   <= SLOT_COUNT_RST;
            r_sis   <= '0;
            r_slot  <= '0;
            r_found <= '0;
            for (int t = 0; t < TRACKS; t++) begin
                r_phase[t] <= '0;
                r_vstep[t] <= '0;
                r_vamp[t]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SLOT_LENGTH: r_len <= i_cfg_data;
                    CFG_SLOT_COUNT:  r_cnt <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.scan_clr) begin
                r_found <= '0;
                for (int t = 0; t < TRACKS; t++) begin
                    r_vstep[t] <= '0;
                    r_vamp[t]  <= '0;
                end
            end
            if (i_cmd.check && w_hit && !r_found[i_cmd.trk]) begin
                r_found[i_cmd.trk] <= 1'b1;
                r_vstep[i_cmd.trk] <= r_entry.phase_step;
                r_vamp[i_cmd.trk]  <= r_entry.amplitude;
            end
            if (i_cmd.ph_step) begin
                r_phase[i_cmd.trk] <= r_phase[i_cmd.trk] + {1'b0, r_vstep[i_cmd.trk]};
            end
            if (i_cmd.out_load) begin
                if (w_slot_done) begin
                    r_sis  <= '0;
                    r_slot <= w_wrap ? 8'd0 : (r_slot + 8'd1);
                end else begin
                    r_sis <= r_sis + 20'd1;
                end
            end
        end
    end

endmodule

// File: hdl/two_voice_tone_sequencer.sv
// two_voice_tone_sequencer: top level, joins the controller and the datapath
// depends on tvts_pkg, tvts_ctrl and tvts_datapath
//
// A write request stores one tone entry. A sample request runs one shared
// voice unit over each track in turn through phase add, registered sine rom
// read, multiply, and round-and-add, then a final step saturates and loads
// the result register. On the first sample of a slot the tone table is first
// scanned one entry per memory read, each read followed by a hit check. A new
// request is taken while the previous result still waits; the final step of a
// sample request holds until the result register is free. Configuration writes
// are taken at any time; write them only while idle.
module two_voice_tone_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic                              i_track,
    input  logic [2:0]                        i_entry_index,
    input  logic [7:0]                        i_begin_slot,
    input  logic [7:0]                        i_end_slot,
    input  logic [30:0]                       i_phase_step,
    input  logic [13:0]                       i_amplitude,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [15:0]                o_sample,
    output logic [7:0]                        o_slot_index,
    output logic                              o_song_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tvts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tvts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tvts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    tvts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tvts_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_track       (i_track),
        .i_entry_index (i_entry_index),
        .i_begin_slot  (i_begin_slot),
        .i_end_slot    (i_end_slot),
        .i_phase_step  (i_phase_step),
        .i_amplitude   (i_amplitude),
        .o_sample      (o_sample),
        .o_slot_index  (o_slot_index),
        .o_song_end    (o_song_end)
    );

endmodule

// File: hdl/tvts_checker.sv
// tvts_assertions: port-level assertions for two_voice_tone_sequencer
// depends on tvts_pkg; attached to the top level by the bind below
module tvts_assertions (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_op,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_sample,
    input logic [7:0]         o_slot_index,
    input logic               o_song_end
);
    import tvts_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample)
            && $stable(o_slot_index) && $stable(o_song_end))
        else $error("stalled result changed");

    // no result appears in the cycle after a request when none was pending
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result without processing time");

    // a sample request keeps the block busy
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_TICK) |=> !o_in_ready)
        else $error("request taken during sample processing");

endmodule

bind two_voice_tone_sequencer tvts_assertions u_tvts_assertions (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_op         (i_op),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample     (o_sample),
    .o_slot_index (o_slot_index),
    .o_song_end   (o_song_end)
);

// File: bench/tvts_checker.sv
`timescale 1ns / 1ps
// tvts_checker: watches the request, result and register channels of the tone sequencer,
// keeps its own model of the voices and compares every sample; depends on tvts_pkg codes

module tvts_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_op,
    input  logic                            i_track,
    input  logic [2:0]                      i_entry_index,
    input  logic [7:0]                      i_begin_slot,
    input  logic [7:0]                      i_end_slot,
    input  logic [30:0]                     i_phase_step,
    input  logic [13:0]                     i_amplitude,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [15:0]              i_sample,
    input  logic [7:0]                      i_slot_index,
    input  logic                            i_song_end,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tvts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tvts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int VOICES   = 2;
    localparam int TONES    = 6;
    localparam int LUT_BITS = 10;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [15:0] value;
        logic [7:0]         slot;
        logic               song_end;
    } voice_sum_t;

    logic signed [15:0] sine_lut [1 << LUT_BITS];

    logic [7:0]  tone_begin [VOICES*TONES];
    logic [7:0]  tone_end   [VOICES*TONES];
    logic [30:0] tone_step  [VOICES*TONES];
    logic [13:0] tone_amp   [VOICES*TONES];

    logic [31:0] voice_phase [VOICES];
    logic [30:0] voice_step  [VOICES];
    logic [13:0] voice_amp   [VOICES];
    logic [7:0]  slot_now;
    logic [19:0] slot_pos;
    logic [19:0] slot_len;
    logic [7:0]  slot_cnt;

    voice_sum_t expected_sums [$];
    voice_sum_t want;
    int fails = 0;
    int shown = 0;
    int waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    // quarter-wave fold, taylor series through x^13 in q30, scaled to q1.15
    function automatic logic signed [15:0] sine_q15(input logic [31:0] ph);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        logic signed [63:0] sum;
        logic signed [15:0] q;
        r = 64'(ph[29:0]);
        if (ph[30]) begin
            r = (64'd1 << 30) - r;
        end
        x    = (r * PI_HALF_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 0; n < 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2*n + 2) * (2*n + 3));
            if (n % 2 == 1) begin
                sum = sum + $signed(term);
            end else begin
                sum = sum - $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        mag = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        q = $signed(mag[15:0]);
        return ph[31] ? -q : q;
    endfunction

    function automatic voice_sum_t next_voice_sum();
        voice_sum_t res;
        int len;
        int cnt;
        int acc;
        int prod;
        int mag;
        int v;
        int k;
        logic found;
        len = (slot_len == 0) ? 1 : int'(slot_len);
        cnt = (slot_cnt == 0) ? 1 : int'(slot_cnt);
        if (slot_pos == 0) begin
            for (int t = 0; t < VOICES; t++) begin
                voice_step[t] = '0;
                voice_amp[t]  = '0;
                found = 1'b0;
                for (int e = 0; e < TONES; e++) begin
                    k = t*TONES + e;
                    if (!found && slot_now >= tone_begin[k] && slot_now <= tone_end[k]) begin
                        voice_step[t] = tone_step[k];
                        voice_amp[t]  = tone_amp[k];
                        found = 1'b1;
                    end
                end
            end
        end
        acc = 0;
        for (int t = 0; t < VOICES; t++) begin
            voice_phase[t] = voice_phase[t] + 32'(voice_step[t]);
            prod = int'(voice_amp[t]) * int'(sine_lut[voice_phase[t][31:32-LUT_BITS]]);
            mag  = (prod < 0) ? -prod : prod;
            v    = (mag + 16384) >>> 15;
            acc  = acc + ((prod < 0) ? -v : v);
        end
        if (acc > 32767) begin
            acc = 32767;
        end
        if (acc < -32768) begin
            acc = -32768;
        end
        res.value    = 16'(acc);
        res.slot     = slot_now;
        res.song_end = (int'(slot_pos) + 1 >= len) && (int'(slot_now) + 1 >= cnt);
        if (int'(slot_pos) + 1 >= len) begin
            slot_pos = '0;
            slot_now = (int'(slot_now) + 1 >= cnt) ? 8'd0 : slot_now + 8'd1;
        end else begin
            slot_pos = slot_pos + 20'd1;
        end
        return res;
    endfunction

    initial begin
        for (int k = 0; k < (1 << LUT_BITS); k++) begin
            sine_lut[k] = sine_q15(32'(k) << (32 - LUT_BITS));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < VOICES; t++) begin
                voice_phase[t] = '0;
                voice_step[t]  = '0;
                voice_amp[t]   = '0;
            end
            slot_now = '0;
            slot_pos = '0;
            slot_len = 20'd19200;
            slot_cnt = 8'd9;
            expected_sums.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tvts_pkg::CFG_SLOT_LENGTH: slot_len = i_cfg_data[19:0];
                    tvts_pkg::CFG_SLOT_COUNT:  slot_cnt = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == tvts_pkg::OP_WRITE) begin
                    if (i_entry_index < TONES) begin
                        tone_begin[int'(i_track)*TONES + int'(i_entry_index)] = i_begin_slot;
                        tone_end[int'(i_track)*TONES + int'(i_entry_index)]   = i_end_slot;
                        tone_step[int'(i_track)*TONES + int'(i_entry_index)]  = i_phase_step;
                        tone_amp[int'(i_track)*TONES + int'(i_entry_index)]   = i_amplitude;
                    end
                end else begin
                    expected_sums.push_back(next_voice_sum());
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    fails++;
                    if (shown < 10) begin
                        $display("%0t: unexpected sample %0d slot %0d end %0b", $realtime,
                                 i_sample, i_slot_index, i_song_end);
                        shown++;
                    end
                end else begin
                    want = expected_sums.pop_front();
                    if (want.value !== i_sample || want.slot !== i_slot_index ||
                        want.song_end !== i_song_end) begin
                        fails++;
                        if (shown < 10) begin
                            $display("%0t: sample mismatch, expected %0d slot %0d end %0b, got %0d slot %0d end %0b",
                                     $realtime, $signed(want.value), want.slot, want.song_end,
                                     i_sample, i_slot_index, i_song_end);
                            shown++;
                        end
                    end
                end
            end
        end
        waiting = expected_sums.size();
    end

endmodule

// File: bench/tb_two_voice_tone_sequencer.sv
`timescale 1ns / 1ps
// tb_two_voice_tone_sequencer: drives tone writes, sample requests and register writes
// into the sequencer with random stalls; depends on tvts_pkg, the block and tvts_checker

module tb_two_voice_tone_sequencer;

    localparam int PHASES = 8;
    localparam int LIMIT  = 600000;
    localparam int LONG_HOLD = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = 1'b0;
    logic        track = 1'b0;
    logic [2:0]  entry_index = '0;
    logic [7:0]  begin_slot = '0;
    logic [7:0]  end_slot = '0;
    logic [30:0] phase_step = '0;
    logic [13:0] amplitude = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] out_sample;
    logic [7:0]  slot_index;
    logic        song_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [tvts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tvts_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    int unsigned phase_len   [PHASES] = '{1, 0, 1, 1048575, 2, 5, 3, 2};
    int unsigned phase_cnt   [PHASES] = '{1, 0, 255, 4, 7, 3, 12, 5};
    int          phase_items [PHASES] = '{150, 60, 450, 150, 220, 170, 170, 180};

    int unsigned song_slots = 9;
    bit          quiet = 1'b0;
    bit          tx_calm = 1'b0;
    int          holds_asked = 0;
    int          holds_done = 0;
    int          long_left = 0;
    int          stall_left = 0;
    int          rx_period = 0;
    bit          rx_calm = 1'b0;
    int          cycles = 0;

    two_voice_tone_sequencer DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_op          (op),
        .i_track       (track),
        .i_entry_index (entry_index),
        .i_begin_slot  (begin_slot),
        .i_end_slot    (end_slot),
        .i_phase_step  (phase_step),
        .i_amplitude   (amplitude),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_sample      (out_sample),
        .o_slot_index  (slot_index),
        .o_song_end    (song_end),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    tvts_checker tone_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_op          (op),
        .i_track       (track),
        .i_entry_index (entry_index),
        .i_begin_slot  (begin_slot),
        .i_end_slot    (end_slot),
        .i_phase_step  (phase_step),
        .i_amplitude   (amplitude),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_sample      (out_sample),
        .i_slot_index  (slot_index),
        .i_song_end    (song_end),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[two_voice_tone_sequencer] ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, calm stretches, and long holds on request
    always @(negedge clk) begin
        if (rx_period == 0) begin
            rx_period = 150;
            rx_calm = ($urandom_range(0, 2) == 0);
        end
        rx_period--;
        if (long_left > 0) begin
            long_left--;
            out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            long_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic idle_input(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_request(input logic op_code, input logic trk, input logic [2:0] idx,
                                input logic [7:0] b, input logic [7:0] e,
                                input logic [30:0] stp, input logic [13:0] amp);
        if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
            idle_input($urandom_range(1, 11));
        end
        in_valid    <= 1'b1;
        op          <= op_code;
        track       <= trk;
        entry_index <= idx;
        begin_slot  <= b;
        end_slot    <= e;
        phase_step  <= stp;
        amplitude   <= amp;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic request_sample();
        send_request(tvts_pkg::OP_TICK, 1'($urandom), 3'($urandom), 8'($urandom),
                     8'($urandom), 31'($urandom), 14'($urandom));
    endtask

    task automatic random_tone_write(output bit kept);
        logic [2:0]  idx;
        logic [7:0]  b;
        logic [7:0]  e;
        logic [30:0] stp;
        logic [13:0] amp;
        int unsigned span;
        span = (song_slots == 0) ? 1 : song_slots;
        idx  = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        if ($urandom_range(0, 4) == 0) begin
            b = 8'($urandom);
            e = 8'($urandom);
        end else begin
            b = 8'($urandom_range(0, span - 1));
            e = 8'($urandom_range(b, span - 1));
        end
        case ($urandom_range(0, 3))
            0: stp = 31'($urandom_range(0, 1 << 24));
            default: stp = 31'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: amp = 14'h3FFF;
            1: amp = '0;
            default: amp = 14'($urandom);
        endcase
        send_request(tvts_pkg::OP_WRITE, 1'($urandom), idx, b, e, stp, amp);
        kept = (idx < 3'd6);
    endtask

    task automatic write_register(input logic [tvts_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tvts_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned len, input int unsigned cnt);
        idle_input(1);
        wait (pending == 0);
        repeat (48) @(negedge clk);
        write_register(tvts_pkg::CFG_SLOT_LENGTH, 20'(len));
        write_register(tvts_pkg::CFG_SLOT_COUNT, (20'($urandom) & 20'hFFF00) | 20'(cnt));
        song_slots = cnt;
    endtask

    initial begin
        int  done;
        bit  kept;
        bit  drained;
        drained = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // full table load first, extremes and empty ranges among the entries
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd0, 8'd5, 8'd3, 31'h7FFFFFFF, 14'h3FFF);
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd1, 8'd0, 8'd0, 31'h7FFFFFFF, 14'h3FFF);
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd2, 8'd0, 8'd255, 31'h0, 14'h3FFF);
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd3, 8'd255, 8'd255, 31'h2AAAAAAA, 14'h2AAA);
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd4, 8'd1, 8'd8, 31'h55555555, 14'h1555);
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd5, 8'd0, 8'd255, 31'h00400000, 14'h0);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd0, 8'd255, 8'd0, 31'h1, 14'h1);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd1, 8'd0, 8'd255, 31'h40000000, 14'h3FFF);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd2, 8'd0, 8'd0, 31'h7FFFFFFF, 14'h0);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd3, 8'd2, 8'd6, 31'h12345678, 14'h2000);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd4, 8'd7, 8'd8, 31'h00010000, 14'h3FFF);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd5, 8'd0, 8'd255, 31'h0, 14'h0);
        // out-of-range entry positions are dropped
        send_request(tvts_pkg::OP_WRITE, 1'b0, 3'd6, 8'd0, 8'd255, 31'h0, 14'h0);
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd7, 8'd0, 8'd255, 31'h0, 14'h0);
        repeat (8) request_sample();
        // rewrite inside the slot, visible only from the next slot
        send_request(tvts_pkg::OP_WRITE, 1'b1, 3'd1, 8'd9, 8'd9, 31'h0, 14'h0);
        repeat (2) request_sample();

        for (int p = 0; p < PHASES; p++) begin
            configure(phase_len[p], phase_cnt[p]);
            quiet = (p == PHASES - 1);
            done = 0;
            while (done < phase_items[p]) begin
                if (done % 40 == 0) begin
                    tx_calm = ($urandom_range(0, 2) == 0);
                end
                if (p == 4 && done == 50 && holds_asked == 0) begin
                    holds_asked++;
                end
                if (p == 5 && done == 80 && !drained) begin
                    idle_input(1);
                    wait (pending == 0);
                    @(negedge clk);
                    drained = 1'b1;
                end
                if ($urandom_range(0, 9) < 7) begin
                    request_sample();
                    done++;
                end else begin
                    random_tone_write(kept);
                    if (kept) begin
                        done++;
                    end
                end
            end
        end

        idle_input(1);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0) begin
            $display("[two_voice_tone_sequencer] OK");
        end else begin
            $display("[two_voice_tone_sequencer] ERROR");
        end
        $finish;
    end

endmodule
